// ===== src/psc_pkg.sv =====
// Shared types and constants for the PID speed controller.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package psc_pkg;

    localparam int SPEED_W    = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 24;
    localparam int TICK_W     = 16;
    localparam int INTEG_W    = 24;
    localparam int INC_W      = 29;
    localparam int INC_LSB    = 4;
    localparam int ISUM_W     = 30;
    localparam int LEVEL_W    = 8;
    localparam int LEVEL_LSB  = 24;
    localparam int I_SHIFT    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = 50;
    localparam int RATE_W     = 34;
    localparam int SPLIT_W    = 17;
    localparam int ACC_W      = 60;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PROP_GAIN   = 3'd0;
    localparam cfg_idx_t CFG_INTEG_GAIN  = 3'd1;
    localparam cfg_idx_t CFG_DERIV_GAIN  = 3'd2;
    localparam cfg_idx_t CFG_TICK_PERIOD = 3'd3;
    localparam cfg_idx_t CFG_TICK_RATE   = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 24'd31457;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 24'd1049;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 24'd8389;
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd1311;
    localparam logic [TICK_W-1:0] TICK_RATE_RST   = 16'd50;

    // +-100 rpm*s in Q8.16
    localparam logic signed [ISUM_W-1:0] INTEG_LIMIT     = 30'sd6553600;
    localparam logic signed [ISUM_W-1:0] INTEG_LIMIT_NEG = -30'sd6553600;
    // +-255 in Q.24
    localparam logic signed [ACC_W-1:0] OUT_LIMIT     = 60'sd4278190080;
    localparam logic signed [ACC_W-1:0] OUT_LIMIT_NEG = -60'sd4278190080;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_PROP,
        ST_INTEG,
        ST_RATE,
        ST_DLO,
        ST_DHI,
        ST_DSUM,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MS_PERIOD,
        MS_PROP,
        MS_INTEG,
        MS_RATE,
        MS_DLO,
        MS_DHI
    } mul_sel_t;

    typedef enum logic [2:0] {
        US_NONE,
        US_INC,
        US_PROP,
        US_INTEG,
        US_SPLIT,
        US_DLO,
        US_DHI
    } use_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        use_sel_t use_sel;
        logic     publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== src/psc_in_if.sv =====
// Input channel of the PID speed controller: one control tick per transfer.
// Depends on psc_pkg for field widths.
`default_nettype none

interface psc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [psc_pkg::SPEED_W-1:0]  target_speed;
    logic signed [psc_pkg::SPEED_W-1:0]  measured_speed;
    logic                                clear_integral;

    modport source (
        output valid, target_speed, measured_speed, clear_integral,
        input  ready
    );
    modport sink (
        input  valid, target_speed, measured_speed, clear_integral,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/psc_out_if.sv =====
// Output channel of the PID speed controller: one drive result per transfer.
// Depends on psc_pkg for field widths.
`default_nettype none

interface psc_out_if;
    logic                               valid;
    logic                               ready;
    logic [psc_pkg::LEVEL_W-1:0]        drive_level;
    logic                               drive_reverse;
    logic                               drive_saturated;
    logic signed [psc_pkg::ERR_W-1:0]   speed_error;

    modport source (
        output valid, drive_level, drive_reverse, drive_saturated, speed_error,
        input  ready
    );
    modport sink (
        input  valid, drive_level, drive_reverse, drive_saturated, speed_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pid_speed_controller_unit.sv =====
// PID speed controller with integral clamp: top level.
// Ticks are taken one at a time: a new input transfer is accepted only once the
// previous tick has finished its six passes through the shared 25x24 multiplier
// plus accumulate and output steps; a result still waiting at the output holds the
// next tick in its final step until the output register is free.
// Reset: gains and tick settings return to defaults, integral and previous error clear.
`default_nettype none

module pid_speed_controller_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data,
    psc_in_if.sink                                 in_ch,
    psc_out_if.source                              out_ch
);

    psc_pkg::ctrl_cmd_t    ctrl_cmd;
    psc_pkg::ctrl_status_t ctrl_status;
    logic                  in_ready;

    psc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (ctrl_status),
        .cmd      (ctrl_cmd)
    );

    psc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_speed    (in_ch.target_speed),
        .measured_speed  (in_ch.measured_speed),
        .clear_integral  (in_ch.clear_integral),
        .cmd             (ctrl_cmd),
        .status          (ctrl_status),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .drive_level     (out_ch.drive_level),
        .drive_reverse   (out_ch.drive_reverse),
        .drive_saturated (out_ch.drive_saturated),
        .speed_error     (out_ch.speed_error)
    );

    assign in_ch.ready = in_ready;

    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input transfer taken while a tick is in progress");

    a_sat_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.drive_saturated)
            |-> (out_ch.drive_level == {psc_pkg::LEVEL_W{1'b1}}))
        else $error("saturated result without full drive level");

    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.publish |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwrote one not yet transferred");

endmodule

`default_nettype wire

// ===== src/psc_ctrl.sv =====
// Sequencer for the PID speed controller: steps the shared multiplier.
// Depends on psc_pkg for the state, command and status types.
`default_nettype none

module psc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire psc_pkg::ctrl_status_t status,
    output psc_pkg::ctrl_cmd_t         cmd
);

    psc_pkg::state_t state_reg;
    psc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_sel = psc_pkg::MS_PERIOD;
        cmd.use_sel = psc_pkg::US_NONE;
        cmd.publish = 1'b0;
        case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = psc_pkg::ST_INC;
                end
            end
            psc_pkg::ST_INC:
            begin
                cmd.mul_sel = psc_pkg::MS_PERIOD;
                state_next  = psc_pkg::ST_PROP;
            end
            psc_pkg::ST_PROP:
            begin
                cmd.mul_sel = psc_pkg::MS_PROP;
                cmd.use_sel = psc_pkg::US_INC;
                state_next  = psc_pkg::ST_INTEG;
            end
            psc_pkg::ST_INTEG:
            begin
                cmd.mul_sel = psc_pkg::MS_INTEG;
                cmd.use_sel = psc_pkg::US_PROP;
                state_next  = psc_pkg::ST_RATE;
            end
            psc_pkg::ST_RATE:
            begin
                cmd.mul_sel = psc_pkg::MS_RATE;
                cmd.use_sel = psc_pkg::US_INTEG;
                state_next  = psc_pkg::ST_DLO;
            end
            psc_pkg::ST_DLO:
            begin
                cmd.mul_sel = psc_pkg::MS_DLO;
                cmd.use_sel = psc_pkg::US_SPLIT;
                state_next  = psc_pkg::ST_DHI;
            end
            psc_pkg::ST_DHI:
            begin
                cmd.mul_sel = psc_pkg::MS_DHI;
                cmd.use_sel = psc_pkg::US_DLO;
                state_next  = psc_pkg::ST_DSUM;
            end
            psc_pkg::ST_DSUM:
            begin
                cmd.use_sel = psc_pkg::US_DHI;
                state_next  = psc_pkg::ST_DONE;
            end
            psc_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = psc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/psc_dp.sv =====
// Datapath of the PID speed controller: configuration registers, loop state,
// one shared 25x24 multiplier, the accumulator and the output register.
// Depends on psc_pkg; driven by commands from psc_ctrl.
`default_nettype none

module psc_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic signed [psc_pkg::SPEED_W-1:0]  target_speed,
    input  wire logic signed [psc_pkg::SPEED_W-1:0]  measured_speed,
    input  wire logic                                clear_integral,
    input  wire psc_pkg::ctrl_cmd_t                  cmd,
    output psc_pkg::ctrl_status_t                    status,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [psc_pkg::LEVEL_W-1:0]              drive_level,
    output logic                                     drive_reverse,
    output logic                                     drive_saturated,
    output logic signed [psc_pkg::ERR_W-1:0]         speed_error
);

    localparam int ERR_W   = psc_pkg::ERR_W;
    localparam int PROD_W  = psc_pkg::PROD_W;
    localparam int ACC_W   = psc_pkg::ACC_W;
    localparam int SPLIT_W = psc_pkg::SPLIT_W;
    localparam int INTEG_W = psc_pkg::INTEG_W;
    localparam int ISUM_W  = psc_pkg::ISUM_W;
    localparam int INC_W   = psc_pkg::INC_W;
    localparam int INC_LSB = psc_pkg::INC_LSB;
    localparam int MUL_A_W = psc_pkg::MUL_A_W;
    localparam int MUL_B_W = psc_pkg::MUL_B_W;
    localparam int I_SHIFT = psc_pkg::I_SHIFT;

    logic [psc_pkg::GAIN_W-1:0]          prop_gain_reg;
    logic [psc_pkg::GAIN_W-1:0]          integ_gain_reg;
    logic [psc_pkg::GAIN_W-1:0]          deriv_gain_reg;
    logic [psc_pkg::TICK_W-1:0]          tick_period_reg;
    logic [psc_pkg::TICK_W-1:0]          tick_rate_reg;

    logic signed [INTEG_W-1:0]           integral_reg;
    logic signed [INTEG_W-1:0]           integral_next;
    logic signed [ERR_W-1:0]             prev_err_reg;
    logic signed [ERR_W-1:0]             err_reg;
    logic signed [ERR_W-1:0]             err_next;
    logic signed [SPLIT_W-1:0]           rhi_reg;
    logic signed [PROD_W-1:0]            prod_reg;
    logic signed [PROD_W-1:0]            prod_next;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [ACC_W-1:0]             acc_next;

    logic                                out_valid_reg;
    logic [psc_pkg::LEVEL_W-1:0]         level_reg;
    logic                                reverse_reg;
    logic                                sat_reg;
    logic signed [ERR_W-1:0]             err_out_reg;

    logic signed [psc_pkg::DIFF_W-1:0]   err_diff;
    logic signed [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]                  mul_b;
    logic signed [MUL_A_W-1:0]           mul_b_s;
    logic signed [INC_W-1:0]             inc;
    logic signed [ISUM_W-1:0]            integ_sum;
    logic signed [ACC_W-1:0]             p_term;
    logic signed [ACC_W-1:0]             i_term;
    logic signed [ACC_W-1:0]             dhi_term;
    logic                                over;
    logic                                under;
    logic signed [ACC_W-1:0]             clamped;
    logic signed [ACC_W-1:0]             mag;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= psc_pkg::PROP_GAIN_RST;
            integ_gain_reg  <= psc_pkg::INTEG_GAIN_RST;
            deriv_gain_reg  <= psc_pkg::DERIV_GAIN_RST;
            tick_period_reg <= psc_pkg::TICK_PERIOD_RST;
            tick_rate_reg   <= psc_pkg::TICK_RATE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                psc_pkg::CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data[psc_pkg::GAIN_W-1:0];
                psc_pkg::CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[psc_pkg::GAIN_W-1:0];
                psc_pkg::CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[psc_pkg::GAIN_W-1:0];
                psc_pkg::CFG_TICK_PERIOD: tick_period_reg <= cfg_data[psc_pkg::TICK_W-1:0];
                psc_pkg::CFG_TICK_RATE:   tick_rate_reg   <= cfg_data[psc_pkg::TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign err_next = {target_speed[psc_pkg::SPEED_W-1], target_speed}
                    - {measured_speed[psc_pkg::SPEED_W-1], measured_speed};
    assign err_diff = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
        mul_b = {{(MUL_B_W-psc_pkg::TICK_W){1'b0}}, tick_period_reg};
        case (cmd.mul_sel)
            psc_pkg::MS_PERIOD:
            begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {{(MUL_B_W-psc_pkg::TICK_W){1'b0}}, tick_period_reg};
            end
            psc_pkg::MS_PROP:
            begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = prop_gain_reg;
            end
            psc_pkg::MS_INTEG:
            begin
                mul_a = {{(MUL_A_W-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg};
                mul_b = integ_gain_reg;
            end
            psc_pkg::MS_RATE:
            begin
                mul_a = {{(MUL_A_W-psc_pkg::DIFF_W){err_diff[psc_pkg::DIFF_W-1]}}, err_diff};
                mul_b = {{(MUL_B_W-psc_pkg::TICK_W){1'b0}}, tick_rate_reg};
            end
            psc_pkg::MS_DLO:
            begin
                mul_a = {{(MUL_A_W-SPLIT_W){1'b0}}, prod_reg[SPLIT_W-1:0]};
                mul_b = deriv_gain_reg;
            end
            psc_pkg::MS_DHI:
            begin
                mul_a = {{(MUL_A_W-SPLIT_W){rhi_reg[SPLIT_W-1]}}, rhi_reg};
                mul_b = deriv_gain_reg;
            end
            default:
            begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {{(MUL_B_W-psc_pkg::TICK_W){1'b0}}, tick_period_reg};
            end
        endcase
    end

    assign mul_b_s   = {{(MUL_A_W-MUL_B_W){1'b0}}, mul_b};
    assign prod_next = mul_a * mul_b_s;

    // floor(e * period / 16), then add and clamp to +-100
    assign inc       = prod_reg[INC_W+INC_LSB-1:INC_LSB];
    assign integ_sum = {{(ISUM_W-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg}
                     + {{(ISUM_W-INC_W){inc[INC_W-1]}}, inc};

    always_comb
    begin
        integral_next = integral_reg;
        if (cmd.load && clear_integral)
        begin
            integral_next = '0;
        end
        else if (cmd.use_sel == psc_pkg::US_INC)
        begin
            if (integ_sum > psc_pkg::INTEG_LIMIT)
            begin
                integral_next = psc_pkg::INTEG_LIMIT[INTEG_W-1:0];
            end
            else if (integ_sum < psc_pkg::INTEG_LIMIT_NEG)
            begin
                integral_next = psc_pkg::INTEG_LIMIT_NEG[INTEG_W-1:0];
            end
            else
            begin
                integral_next = integ_sum[INTEG_W-1:0];
            end
        end
    end

    assign p_term   = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign i_term   = {{(ACC_W-PROD_W+I_SHIFT){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:I_SHIFT]};
    assign dhi_term = {prod_reg[ACC_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.use_sel)
            psc_pkg::US_PROP:  acc_next = p_term;
            psc_pkg::US_INTEG: acc_next = acc_reg + i_term;
            psc_pkg::US_DLO:   acc_next = acc_reg + p_term;
            psc_pkg::US_DHI:   acc_next = acc_reg + dhi_term;
            default:           acc_next = acc_reg;
        endcase
    end

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            integral_reg <= integral_next;
            if (cmd.use_sel == psc_pkg::US_DHI)
            begin
                prev_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load)
        begin
            err_reg <= err_next;
        end
        if (cmd.use_sel == psc_pkg::US_SPLIT)
        begin
            rhi_reg <= prod_reg[psc_pkg::RATE_W-1:SPLIT_W];
        end
    end

    // output clamp and magnitude
    assign over    = acc_reg > psc_pkg::OUT_LIMIT;
    assign under   = acc_reg < psc_pkg::OUT_LIMIT_NEG;
    assign clamped = over ? psc_pkg::OUT_LIMIT : (under ? psc_pkg::OUT_LIMIT_NEG : acc_reg);
    assign mag     = clamped[ACC_W-1] ? -clamped : clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            level_reg   <= mag[psc_pkg::LEVEL_LSB+psc_pkg::LEVEL_W-1:psc_pkg::LEVEL_LSB];
            reverse_reg <= acc_reg[ACC_W-1];
            sat_reg     <= over | under;
            err_out_reg <= err_reg;
        end
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign drive_level     = level_reg;
    assign drive_reverse   = reverse_reg;
    assign drive_saturated = sat_reg;
    assign speed_error     = err_out_reg;

endmodule

`default_nettype wire
